// ----- design/afd_pkg.sv -----
// Types and constants shared by the API frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package afd_pkg;

   localparam logic [7:0] START_MARK = 8'h7E;
   localparam logic [7:0] SUM_BASE   = 8'hFF;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_LEN_HI = 3'd1,
      PH_LEN_LO = 3'd2,
      PH_DATA   = 3'd3,
      PH_CHECK  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_SUM_ERR = 2'd2,
      KIND_LEN_ERR = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [15:0] declared_len;
   } result_type;

   typedef struct packed {
      logic       has_result;
      result_type result;
   } step_type;

endpackage
`default_nettype wire

// ----- design/afd_stream_if.sv -----
// Request and response channel interfaces of the deframer.
`timescale 1ns / 1ps
`default_nettype none
interface afd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface afd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  data_byte;
   logic [7:0]  byte_index;
   logic [15:0] declared_len;

   modport source (output valid, output result_kind, output data_byte,
                   output byte_index, output declared_len, input ready);
   modport sink (input valid, input result_kind, input data_byte,
                 input byte_index, input declared_len, output ready);
endinterface
`default_nettype wire

// ----- design/afd_parser.sv -----
// Frame parse state machine: phase, length, count and checksum per byte.
`timescale 1ns / 1ps
`default_nettype none
module afd_parser #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire logic [7:0]       rx_byte,
   output afd_pkg::step_type     step
);

   localparam logic [16:0] MaxLen = 17'(MAX_FRAME_BYTES);

   afd_pkg::phase_type phase_ff, phase_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] full_len;
   logic [15:0] count_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= afd_pkg::PH_HUNT;
         length_ff <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
      end else if (take) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
      end
   end

   assign full_len   = {length_ff[15:8], rx_byte};
   assign count_next = count_ff + 16'd1;

   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      step      = '0;
      case (phase_ff)
         afd_pkg::PH_LEN_HI: begin
            length_in = {rx_byte, 8'h00};
            phase_in  = afd_pkg::PH_LEN_LO;
         end
         afd_pkg::PH_LEN_LO: begin
            count_in = '0;
            sum_in   = '0;
            if (full_len == 16'd0 || {1'b0, full_len} > MaxLen) begin
               step.has_result          = 1'b1;
               step.result.result_kind  = afd_pkg::KIND_LEN_ERR;
               step.result.declared_len = full_len;
               length_in = '0;
               phase_in  = afd_pkg::PH_HUNT;
            end else begin
               length_in = full_len;
               phase_in  = afd_pkg::PH_DATA;
            end
         end
         afd_pkg::PH_DATA: begin
            step.has_result          = 1'b1;
            step.result.result_kind  = afd_pkg::KIND_DATA;
            step.result.data_byte    = rx_byte;
            step.result.byte_index   = count_ff[7:0];
            step.result.declared_len = length_ff;
            sum_in   = sum_ff + rx_byte;
            count_in = count_next;
            if (count_next >= length_ff) begin
               phase_in = afd_pkg::PH_CHECK;
            end
         end
         afd_pkg::PH_CHECK: begin
            step.has_result          = 1'b1;
            step.result.declared_len = length_ff;
            if (rx_byte == afd_pkg::SUM_BASE - sum_ff) begin
               step.result.result_kind = afd_pkg::KIND_GOOD;
            end else begin
               step.result.result_kind = afd_pkg::KIND_SUM_ERR;
            end
            phase_in  = afd_pkg::PH_HUNT;
            length_in = '0;
            count_in  = '0;
            sum_in    = '0;
         end
         default: begin
            // hunting; unused phase codes act the same
            length_in = '0;
            count_in  = '0;
            sum_in    = '0;
            if (rx_byte == afd_pkg::START_MARK) begin
               phase_in = afd_pkg::PH_LEN_HI;
            end else begin
               phase_in = afd_pkg::PH_HUNT;
            end
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- design/api_frame_deframer_top.sv -----
// A result is written to the response register when its request is taken.
// Throughput: one request per cycle unless a held response stalls it; the checksum is updated as each byte is taken.
// The request side stalls only while a held response is not taken.
// Reset: synchronous, active high; hunting for the start delimiter, count,
// length and sum cleared, no response pending.
`timescale 1ns / 1ps
`default_nettype none
module api_frame_deframer_top #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input wire logic   clock,
   input wire logic   reset,
   afd_req_if.sink    req_if,
   afd_rsp_if.source  rsp_if
);

   logic               take;
   afd_pkg::step_type  step;
   logic               rsp_valid_ff, rsp_valid_in;
   afd_pkg::result_type rsp_data_ff;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign take         = req_if.valid && req_if.ready;

   afd_parser #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_if.rx_byte),
      .step    (step)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = step.has_result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the response payload until a new result replaces it
   always_ff @(posedge clock) begin
      if (take && step.has_result) begin
         rsp_data_ff <= step.result;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_kind  = rsp_data_ff.result_kind;
   assign rsp_if.data_byte    = rsp_data_ff.data_byte;
   assign rsp_if.byte_index   = rsp_data_ff.byte_index;
   assign rsp_if.declared_len = rsp_data_ff.declared_len;

endmodule
`default_nettype wire

// ----- design/afd_checker.sv -----
// Port checker for the deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module afd_port_checks #(
   parameter int MAX_FRAME_BYTES = 256
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_result_kind,
   input wire logic [7:0]  rsp_data_byte,
   input wire logic [7:0]  rsp_byte_index,
   input wire logic [15:0] rsp_declared_len
);

   localparam logic [16:0] MaxLen = 17'(MAX_FRAME_BYTES);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled response dropped");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   a_end_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != afd_pkg::KIND_DATA
         |-> rsp_data_byte == 8'd0 && rsp_byte_index == 8'd0)
      else $error("end or error response carries data fields");

   a_data_len_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == afd_pkg::KIND_DATA
         |-> rsp_declared_len != 16'd0 && {1'b0, rsp_declared_len} <= MaxLen)
      else $error("data response with out of range frame length");

endmodule

bind api_frame_deframer_top afd_port_checks #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_afd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_result_kind  (rsp_if.result_kind),
   .rsp_data_byte    (rsp_if.data_byte),
   .rsp_byte_index   (rsp_if.byte_index),
   .rsp_declared_len (rsp_if.declared_len)
);
`default_nettype wire
